// ===== sv/mi4inv_pkg.sv =====
// shared types, constants and helper functions for the 4x4 adjugate inverse
package mi4inv_pkg;

  // number format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 98;
  localparam int CMAG_W    = 96;
  localparam int DET_W     = 132;
  localparam int DMAG_W    = 131;
  localparam int DS_W      = DMAG_W + 33;
  localparam int NUM_SH    = 2 * FRAC_BITS + 1;
  localparam int Q_W       = 33;

  // operand select for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_LDX  = 3'd1,
    MUL_XY   = 3'd2,
    MUL_LOZ  = 3'd3,
    MUL_HIZ  = 3'd4,
    MUL_COF  = 3'd5
  } mul_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic       st_we;
    logic [3:0] st_addr;
    mul_op_t    mul_op;
    logic [3:0] rd_addr;
    logic [1:0] limb;
    logic       term_neg;
    logic       acc_clr;
    logic       acc_en;
    logic       acc_hi;
    logic       adj_we;
    logic [3:0] adj_addr;
    logic       det_clr;
    logic       det_en;
    logic [1:0] det_sh;
    logic       fin;
    logic       div_load;
    logic [3:0] div_addr;
    logic       div_step;
    logic       out_load;
    logic [3:0] out_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sing;
    logic out_free;
  } status_t;

  // column taken by position i of permutation p
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
    logic [5:0] row;
    unique case (p)
      3'd0:    row = {2'd2, 2'd1, 2'd0};
      3'd1:    row = {2'd1, 2'd2, 2'd0};
      3'd2:    row = {2'd2, 2'd0, 2'd1};
      3'd3:    row = {2'd0, 2'd2, 2'd1};
      3'd4:    row = {2'd1, 2'd0, 2'd2};
      3'd5:    row = {2'd0, 2'd1, 2'd2};
      default: row = 6'd0;
    endcase
    unique case (i)
      2'd0:    return row[1:0];
      2'd1:    return row[3:2];
      2'd2:    return row[5:4];
      default: return 2'd0;
    endcase
  endfunction

  // odd permutations flip the sign of their term
  function automatic logic perm_odd(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // i-th index of the 3 remaining after removing x
  function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] x);
    return (i >= x) ? i + 2'd1 : i;
  endfunction

  // magnitude of a signed element, fits unsigned 32 bits
  function automatic logic [ELEM_W-1:0] elem_mag(input logic [ELEM_W-1:0] v);
    return v[ELEM_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== sv/mi4inv_if.sv =====
// valid/ready channel interfaces for matrix elements in and inverse elements out
interface mi4inv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_in;

  modport source (output valid, output element_in, input ready);
  modport sink   (input valid, input element_in, output ready);
endinterface

interface mi4inv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_out;
  logic [3:0]  element_index;
  logic        singular;
  logic        saturated;
  logic        last_element;

  modport source (output valid, output element_out, output element_index,
                  output singular, output saturated, output last_element,
                  input ready);
  modport sink   (input valid, input element_out, input element_index,
                  input singular, input saturated, input last_element,
                  output ready);
endinterface

// ===== sv/mi4inv_dp.sv =====
// datapath: matrix store, shared multiplier, accumulators, divider, output register
module mi4inv_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mi4inv_pkg::cmd_t     cmd,
  input  logic [31:0]          in_elem,
  output mi4inv_pkg::status_t  sts,
  mi4inv_out_if.source         out_ch
);

  logic [mi4inv_pkg::ELEM_W-1:0] store_r [16];
  logic [mi4inv_pkg::ACC_W-1:0]  adj_r [16];
  logic [mi4inv_pkg::ELEM_W-1:0] x_r;
  logic [mi4inv_pkg::PROD_W-1:0] prod_r;
  logic [mi4inv_pkg::PROD_W-1:0] pp_r;
  logic                          tsg_r;
  logic                          dtsg_r;
  logic [mi4inv_pkg::ACC_W-1:0]  acc_r;
  logic [mi4inv_pkg::CMAG_W-1:0] cm_r;
  logic                          dsg_r;
  logic [mi4inv_pkg::DET_W-1:0]  det_r;
  logic                          dneg_r;
  logic                          sing_r;
  logic [mi4inv_pkg::DMAG_W-1:0] dmag_r;
  logic [mi4inv_pkg::DS_W-1:0]   rem_r;
  logic [mi4inv_pkg::DS_W-1:0]   ds_r;
  logic [mi4inv_pkg::Q_W-1:0]    q_r;
  logic                          aneg_r;
  logic                          ov_r;
  logic [31:0]                   oval_r;
  logic [3:0]                    oidx_r;
  logic                          osing_r;
  logic                          osat_r;

  logic [mi4inv_pkg::ELEM_W-1:0] rd;
  logic [mi4inv_pkg::ELEM_W-1:0] rd_mag;
  logic [mi4inv_pkg::ELEM_W-1:0] mul_a;
  logic [mi4inv_pkg::PROD_W-1:0] mul_p;
  logic [mi4inv_pkg::ACC_W-1:0]  acc_t;
  logic [mi4inv_pkg::DET_W-1:0]  det_t;
  logic [mi4inv_pkg::ACC_W-1:0]  adj_rd;
  logic [mi4inv_pkg::CMAG_W-1:0] adj_mag;
  logic                          ge;
  logic                          qneg;
  logic [31:0]                   qlo;
  logic [31:0]                   limit;
  logic                          sat;
  logic [31:0]                   val;
  logic                          out_free;

  // single read port on the element store
  assign rd     = store_r[cmd.rd_addr];
  assign rd_mag = mi4inv_pkg::elem_mag(rd);

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_op)
      mi4inv_pkg::MUL_XY:  mul_a = x_r;
      mi4inv_pkg::MUL_LOZ: mul_a = prod_r[31:0];
      mi4inv_pkg::MUL_HIZ: mul_a = prod_r[63:32];
      mi4inv_pkg::MUL_COF: begin
        unique case (cmd.limb)
          2'd0:    mul_a = cm_r[31:0];
          2'd1:    mul_a = cm_r[63:32];
          2'd2:    mul_a = cm_r[95:64];
          default: mul_a = '0;
        endcase
      end
      default:             mul_a = '0;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, rd_mag};

  // shifted partial products for the two accumulators
  assign acc_t   = mi4inv_pkg::ACC_W'(pp_r) << (cmd.acc_hi ? 7'd32 : 7'd0);
  assign det_t   = mi4inv_pkg::DET_W'(pp_r) << {cmd.det_sh, 5'd0};
  assign adj_rd  = adj_r[cmd.div_addr];
  assign adj_mag = mi4inv_pkg::CMAG_W'(adj_rd[mi4inv_pkg::ACC_W-1] ? (~adj_rd + 1'b1) : adj_rd);
  assign ge      = rem_r >= ds_r;

  // element store writes
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      store_r[cmd.st_addr] <= in_elem;
    end
  end

  // multiplier and term sign registers
  always_ff @(posedge clk) begin
    unique case (cmd.mul_op)
      mi4inv_pkg::MUL_LDX: x_r <= rd_mag;
      mi4inv_pkg::MUL_XY: begin
        prod_r <= mul_p;
        tsg_r  <= cmd.term_neg ^ tsg_r ^ rd[31];
      end
      mi4inv_pkg::MUL_LOZ: begin
        pp_r  <= mul_p;
        tsg_r <= tsg_r ^ rd[31];
      end
      mi4inv_pkg::MUL_HIZ: pp_r <= mul_p;
      mi4inv_pkg::MUL_COF: begin
        pp_r <= mul_p;
        if (cmd.limb == 2'd0) begin
          dtsg_r <= dsg_r ^ rd[31];
        end
      end
      default: ;
    endcase
    // load of x carries its sign into the term sign
    if (cmd.mul_op == mi4inv_pkg::MUL_LDX) begin
      tsg_r <= rd[31];
    end
  end

  // cofactor accumulator and adjugate store
  always_ff @(posedge clk) begin
    if (cmd.adj_we) begin
      adj_r[cmd.adj_addr] <= acc_r;
      cm_r  <= mi4inv_pkg::CMAG_W'(acc_r[mi4inv_pkg::ACC_W-1] ? (~acc_r + 1'b1) : acc_r);
      dsg_r <= acc_r[mi4inv_pkg::ACC_W-1];
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= tsg_r ? acc_r - acc_t : acc_r + acc_t;
    end
  end

  // determinant accumulation and its magnitude
  always_ff @(posedge clk) begin
    if (cmd.det_clr) begin
      det_r <= '0;
    end else if (cmd.det_en) begin
      det_r <= dtsg_r ? det_r - det_t : det_r + det_t;
    end
    if (cmd.fin) begin
      dneg_r <= det_r[mi4inv_pkg::DET_W-1];
      dmag_r <= mi4inv_pkg::DMAG_W'(det_r[mi4inv_pkg::DET_W-1] ? (~det_r + 1'b1) : det_r);
      sing_r <= (det_r == '0);
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      aneg_r <= adj_rd[mi4inv_pkg::ACC_W-1];
      rem_r  <= (mi4inv_pkg::DS_W'(adj_mag) << mi4inv_pkg::NUM_SH)
                + mi4inv_pkg::DS_W'(dmag_r);
      ds_r   <= mi4inv_pkg::DS_W'(dmag_r) << 33;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      ds_r <= ds_r >> 1;
      q_r  <= {q_r[mi4inv_pkg::Q_W-2:0], ge};
    end
  end

  // sign, saturation and zero on singular
  always_comb begin
    qneg  = aneg_r ^ dneg_r;
    qlo   = q_r[31:0];
    limit = qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat   = !sing_r && (q_r[mi4inv_pkg::Q_W-1] || (qlo > limit));
    if (sing_r) begin
      val = '0;
    end else if (sat) begin
      val = limit;
    end else begin
      val = qneg ? (~qlo + 1'b1) : qlo;
    end
  end

  assign out_free = !ov_r || out_ch.ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oval_r  <= val;
      oidx_r  <= cmd.out_idx;
      osing_r <= sing_r;
      osat_r  <= sat;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.element_out   = oval_r;
  assign out_ch.element_index = oidx_r;
  assign out_ch.singular      = osing_r;
  assign out_ch.saturated     = osat_r;
  assign out_ch.last_element  = (oidx_r == 4'd15);

  assign sts.sing     = sing_r;
  assign sts.out_free = out_free;

  // a singular result carries zero and no clip
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && osing_r |-> (oval_r == 32'd0) && !osat_r)
    else $error("singular result not zero");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && osat_r |-> (oval_r == 32'h8000_0000) || (oval_r == 32'h7FFF_FFFF))
    else $error("clipped result off the limits");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !ov_r || out_ch.ready)
    else $error("result overwritten");

endmodule

// ===== sv/mi4inv_ctrl.sv =====
// controller: load counter and sequencer for cofactors, determinant and division
module mi4inv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mi4inv_pkg::status_t sts,
  output mi4inv_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_TERM  = 8'b0000_0010,
    S_ADJ   = 8'b0000_0100,
    S_DET   = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_DLOAD = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] ld_r, ld_nxt;
  logic [3:0] k_r, k_nxt;
  logic [2:0] p_r, p_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [5:0] dv_r, dv_nxt;
  logic [3:0] o_r, o_nxt;

  logic       in_fire;
  logic [1:0] row;
  logic [1:0] col;
  logic [1:0] pos;
  logic       last_cof;

  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign row      = k_r[3:2];
  assign col      = k_r[1:0];
  assign last_cof = (k_r == 4'd15);

  // which of the three minor rows the current phase reads
  always_comb begin
    unique case (ph_r)
      3'd0:    pos = 2'd0;
      3'd1:    pos = 2'd1;
      default: pos = 2'd2;
    endcase
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ld_nxt    = ld_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    ph_nxt    = ph_r;
    dv_nxt    = dv_r;
    o_nxt     = o_r;
    cmd       = '0;
    cmd.mul_op   = mi4inv_pkg::MUL_NONE;
    cmd.st_addr  = ld_r;
    cmd.adj_addr = {col, row};
    cmd.div_addr = o_r;
    cmd.out_idx  = o_r;
    cmd.rd_addr  = {mi4inv_pkg::skip_idx(pos, row),
                    mi4inv_pkg::skip_idx(mi4inv_pkg::perm_col(p_r, pos), col)};
    cmd.term_neg = mi4inv_pkg::perm_odd(p_r) ^ row[0] ^ col[0];
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          cmd.st_we = 1'b1;
          ld_nxt    = ld_r + 4'd1;
          if (ld_r == 4'd15) begin
            cmd.acc_clr = 1'b1;
            cmd.det_clr = 1'b1;
            k_nxt       = '0;
            p_nxt       = '0;
            ph_nxt      = '0;
            state_nxt   = S_TERM;
          end
        end
      end
      S_TERM: begin
        // one triple product in five phases
        unique case (ph_r)
          3'd0: cmd.mul_op = mi4inv_pkg::MUL_LDX;
          3'd1: cmd.mul_op = mi4inv_pkg::MUL_XY;
          3'd2: cmd.mul_op = mi4inv_pkg::MUL_LOZ;
          3'd3: begin
            cmd.mul_op = mi4inv_pkg::MUL_HIZ;
            cmd.acc_en = 1'b1;
          end
          default: begin
            cmd.acc_en = 1'b1;
            cmd.acc_hi = 1'b1;
          end
        endcase
        if (ph_r == 3'd4) begin
          ph_nxt = '0;
          if (p_r == 3'd5) begin
            state_nxt = S_ADJ;
          end else begin
            p_nxt = p_r + 3'd1;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_ADJ: begin
        cmd.adj_we  = 1'b1;
        cmd.acc_clr = 1'b1;
        p_nxt       = '0;
        ph_nxt      = '0;
        if (row == 2'd0) begin
          state_nxt = S_DET;
        end else if (last_cof) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_TERM;
        end
      end
      S_DET: begin
        // first-row cofactor times its element, limb by limb
        cmd.rd_addr = {2'd0, col};
        cmd.limb    = ph_r[1:0];
        if (ph_r != 3'd3) begin
          cmd.mul_op = mi4inv_pkg::MUL_COF;
        end
        if (ph_r != 3'd0) begin
          cmd.det_en = 1'b1;
          cmd.det_sh = 2'(ph_r - 3'd1);
        end
        if (ph_r == 3'd3) begin
          ph_nxt    = '0;
          k_nxt     = k_r + 4'd1;
          state_nxt = S_TERM;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        o_nxt     = '0;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        if (sts.sing) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_load = 1'b1;
          dv_nxt       = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dv_nxt       = dv_r + 6'd1;
        if (dv_r == 6'd32) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          o_nxt        = o_r + 4'd1;
          state_nxt    = (o_r == 4'd15) ? S_LOAD : S_DLOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ld_r    <= '0;
      k_r     <= '0;
      p_r     <= '0;
      ph_r    <= '0;
      dv_r    <= '0;
      o_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ld_r    <= ld_nxt;
      k_r     <= k_nxt;
      p_r     <= p_nxt;
      ph_r    <= ph_nxt;
      dv_r    <= dv_nxt;
      o_r     <= o_nxt;
    end
  end

  // the sixteenth element starts the cofactor pass
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (ld_r == 4'd15) |=> (state_r == S_TERM) && (k_r == 4'd0))
    else $error("compute did not start after last element");

  // the divider never runs past its 33 steps
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dv_r <= 6'd32))
    else $error("divider overran");

  // the load count sits at zero whenever compute is under way
  a_ld_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (ld_r == 4'd0))
    else $error("load count not wrapped");

endmodule

// ===== sv/matrix4_inverse_adjugate.sv =====
// top level: 4x4 fixed point matrix inverse by adjugate and determinant
// operation: 16 element transfers, then cofactors and determinant on one
//   shared 32x32 multiplier, then the determinant is finished, then each result
//   comes from a 33-step bit-serial divider
// input: a new matrix is accepted only after the last result of the previous one is loaded for output
// singular matrix: the divider is skipped and zero results follow the determinant as the output frees
// reset: rst_n synchronous active low; clears the load count, sequencer and output valid
module matrix4_inverse_adjugate (
  input  logic          clk,
  input  logic          rst_n,
  mi4inv_in_if.sink     in_ch,
  mi4inv_out_if.source  out_ch
);

  mi4inv_pkg::cmd_t    cmd;
  mi4inv_pkg::status_t sts;

  // sequencer
  mi4inv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  mi4inv_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_elem (in_ch.element_in),
    .sts     (sts),
    .out_ch  (out_ch)
  );

endmodule
